// ===== src/ppd_pkg.sv =====
// Package for the perspective projection block: default widths and the
// configuration register indexes. Used by every module under src.
package ppd_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned CfgIdxWidth   = 8;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    RegXScale      = 8'd0,
    RegYScale      = 8'd1,
    RegDepthScale  = 8'd2,
    RegDepthOffset = 8'd3
  } cfg_reg_e;

endpackage

// ===== src/ppd_mul.sv =====
// Front end of the projection pipeline: products, depth sum and magnitudes.
// Two register stages. Depends on ppd_pkg.
module ppd_mul
  import ppd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] x_scale_i,
  input  logic signed [COORD_WIDTH-1:0] y_scale_i,
  input  logic signed [COORD_WIDTH-1:0] depth_scale_i,
  input  logic signed [COORD_WIDTH-1:0] depth_offset_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] z_i,
  input  logic signed [COORD_WIDTH-1:0] w_i,
  output logic [2*COORD_WIDTH:0]        mag_x_o,
  output logic [2*COORD_WIDTH:0]        mag_y_o,
  output logic [2*COORD_WIDTH:0]        mag_z_o,
  output logic                          neg_x_o,
  output logic                          neg_y_o,
  output logic                          neg_z_o,
  output logic [COORD_WIDTH-1:0]        zmag_o
);

  localparam int unsigned W = COORD_WIDTH;

  logic signed [2*W-1:0] px_q, py_q, pz_q, pw_q;
  logic signed [W-1:0]   zs_q;
  logic signed [2*W:0]   sum_z;
  logic [2*W:0]          mag_x_q, mag_y_q, mag_z_q;
  logic                  neg_x_q, neg_y_q, neg_z_q;
  logic [W-1:0]          zmag_q;
  logic                  zneg;

  // Stage one: the four products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= x_scale_i * x_i;
      py_q <= y_scale_i * y_i;
      pz_q <= depth_scale_i * z_i;
      pw_q <= depth_offset_i * w_i;
      zs_q <= z_i;
    end
  end

  // Stage two: depth sum, magnitudes and quotient signs.
  assign sum_z = {pz_q[2*W-1], pz_q} + {pw_q[2*W-1], pw_q};
  assign zneg  = zs_q[W-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_x_q <= px_q[2*W-1] ? -{px_q[2*W-1], px_q} : {1'b0, px_q};
      mag_y_q <= py_q[2*W-1] ? -{py_q[2*W-1], py_q} : {1'b0, py_q};
      mag_z_q <= sum_z[2*W] ? -sum_z : sum_z;
      neg_x_q <= px_q[2*W-1] ^ zneg;
      neg_y_q <= py_q[2*W-1] ^ zneg;
      neg_z_q <= sum_z[2*W] ^ zneg;
      zmag_q  <= zneg ? -zs_q : zs_q;
    end
  end

  assign mag_x_o = mag_x_q;
  assign mag_y_o = mag_y_q;
  assign mag_z_o = mag_z_q;
  assign neg_x_o = neg_x_q;
  assign neg_y_o = neg_y_q;
  assign neg_z_o = neg_z_q;
  assign zmag_o  = zmag_q;

endmodule

// ===== src/ppd_div.sv =====
// One lane of the pipelined restoring divider with saturation, one quotient
// bit per stage, COORD_WIDTH+1 register stages. Depends on ppd_pkg.
module ppd_div
  import ppd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2*COORD_WIDTH:0] mag_i,
  input  logic [COORD_WIDTH-1:0] zmag_i,
  input  logic                   neg_i,
  output logic [COORD_WIDTH-1:0] res_o,
  output logic                   sat_o
);

  localparam int unsigned W = COORD_WIDTH;

  logic [W-1:0] rem_q  [W+1];
  logic [W-1:0] low_q  [W+1];
  logic [W-1:0] quo_q  [W+1];
  logic [W-1:0] zmag_q [W+1];
  logic         neg_q  [W+1];
  logic         ovf_q  [W+1];

  // Entry stage: a quotient of 2^W or more is already known to overflow.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= mag_i[2*W-1:W];
      low_q[0]  <= mag_i[W-1:0];
      quo_q[0]  <= '0;
      zmag_q[0] <= zmag_i;
      neg_q[0]  <= neg_i;
      ovf_q[0]  <= mag_i[2*W:W] >= {1'b0, zmag_i};
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0] trial;
    logic       ge;
    assign trial = {rem_q[k], low_q[k][W-1]};
    assign ge    = trial >= {1'b0, zmag_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? W'(trial - {1'b0, zmag_q[k]}) : trial[W-1:0];
        low_q[k+1]  <= {low_q[k][W-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][W-2:0], ge};
        zmag_q[k+1] <= zmag_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end
  end

  // Clamp to the range of the sign, then apply the sign.
  logic [W-1:0] limit;
  logic [W-1:0] mag;
  logic         sat;
  assign limit = neg_q[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign sat   = ovf_q[W] || (quo_q[W] > limit);
  assign mag   = sat ? limit : quo_q[W];
  assign res_o = neg_q[W] ? -mag : mag;
  assign sat_o = sat;

endmodule

// ===== src/perspective_project_divide.sv =====
// Top level of the perspective projection with homogeneous divide.
// Depends on ppd_pkg, ppd_mul and ppd_div.
//
//   channel  direction  handshake                   payload
//   s_axis   in         s_axis_tvalid/tready        x, y, z, w
//   m_axis   out        m_axis_tvalid/tready        x, y, z; tuser flags
//   cfg      in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One point enters per cycle unless the output stalls. A result crosses the
// multiplier, divider lanes (one quotient bit per stage) and output register.
// Reset clears the valid bits and loads the coefficient reset values.
// A stall at the output freezes every stage at once; nothing is lost.
module perspective_project_divide
  import ppd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // x_in, y_in, z_in, w_in from the lowest bit up
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // x_out, y_out, z_out from the lowest bit up
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // zero_divisor, saturated from the lowest bit up
  output logic [1:0]                              m_axis_tuser,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]                  cfg_index_i,
  input  logic [COORD_WIDTH-1:0]                  cfg_data_i
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned Lat    = W + 3;
  localparam int unsigned OutW   = ((3*W+7)/8)*8;
  localparam logic [W-1:0] One   = W'(1) << FRAC_BITS;

  logic signed [W-1:0] x_scale_q, y_scale_q, depth_scale_q, depth_offset_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_scale_q      <= One;
      y_scale_q      <= One;
      depth_scale_q  <= One;
      depth_offset_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegXScale:      x_scale_q      <= cfg_data_i;
        RegYScale:      y_scale_q      <= cfg_data_i;
        RegDepthScale:  depth_scale_q  <= cfg_data_i;
        RegDepthOffset: depth_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: move when the output register is empty or being drained.
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [W-1:0] x_in, y_in, z_in, w_in;
  assign x_in = s_axis_tdata[W-1:0];
  assign y_in = s_axis_tdata[2*W-1:W];
  assign z_in = s_axis_tdata[3*W-1:2*W];
  assign w_in = s_axis_tdata[4*W-1:3*W];

  // Valid bits and the zero-divisor flag travel alongside the lanes.
  logic [Lat-1:0] vld_q;
  logic [Lat-1:0] zd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      zd_q <= {zd_q[Lat-2:0], (z_in == '0)};
    end
  end

  logic [2*W:0] mag_x, mag_y, mag_z;
  logic         neg_x, neg_y, neg_z;
  logic [W-1:0] zmag;

  ppd_mul #(.COORD_WIDTH(W)) u_mul (
    .clk_i          (clk_i),
    .en_i           (en),
    .x_scale_i      (x_scale_q),
    .y_scale_i      (y_scale_q),
    .depth_scale_i  (depth_scale_q),
    .depth_offset_i (depth_offset_q),
    .x_i            (x_in),
    .y_i            (y_in),
    .z_i            (z_in),
    .w_i            (w_in),
    .mag_x_o        (mag_x),
    .mag_y_o        (mag_y),
    .mag_z_o        (mag_z),
    .neg_x_o        (neg_x),
    .neg_y_o        (neg_y),
    .neg_z_o        (neg_z),
    .zmag_o         (zmag)
  );

  logic [W-1:0] res_x, res_y, res_z;
  logic         sat_x, sat_y, sat_z;

  ppd_div #(.COORD_WIDTH(W)) u_div_x (
    .clk_i (clk_i), .en_i (en), .mag_i (mag_x), .zmag_i (zmag), .neg_i (neg_x),
    .res_o (res_x), .sat_o (sat_x)
  );
  ppd_div #(.COORD_WIDTH(W)) u_div_y (
    .clk_i (clk_i), .en_i (en), .mag_i (mag_y), .zmag_i (zmag), .neg_i (neg_y),
    .res_o (res_y), .sat_o (sat_y)
  );
  ppd_div #(.COORD_WIDTH(W)) u_div_z (
    .clk_i (clk_i), .en_i (en), .mag_i (mag_z), .zmag_i (zmag), .neg_i (neg_z),
    .res_o (res_z), .sat_o (sat_z)
  );

  // Output register; a zero divisor forces zero results and no saturation.
  logic [W-1:0] x_out_q, y_out_q, z_out_q;
  logic         zd_out_q, sat_out_q;
  logic         zd_last;
  assign zd_last = zd_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[Lat-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x_out_q   <= zd_last ? '0 : res_x;
      y_out_q   <= zd_last ? '0 : res_y;
      z_out_q   <= zd_last ? '0 : res_z;
      zd_out_q  <= zd_last;
      sat_out_q <= !zd_last && (sat_x || sat_y || sat_z);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({z_out_q, y_out_q, x_out_q});
  assign m_axis_tuser  = {sat_out_q, zd_out_q};

  // The input side stalls exactly when a held result is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  // A zero divisor gives zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("zero divisor result carries nonzero data");

  // A zero divisor never reports saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
    else $error("zero divisor result flagged as saturated");

  // An accepted transaction leaves the first pipeline stage valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted point lost at pipeline entry");

endmodule
